// ===== design/cdss_pkg.sv =====
// Shared package of the card deck store: widths, request codes, controller
// states and the command and status bundles between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package cdss_pkg;

  localparam int unsigned MAX_CARDS_DEF = 64;

  localparam int unsigned CNT_W   = 7;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned VAL_W   = 4;
  localparam int unsigned REQ_W   = 3;

  localparam int unsigned STD_VALUES = 13;
  localparam int unsigned STD_SUITS  = 4;
  localparam int unsigned STD_DECK   = STD_VALUES * STD_SUITS;
  localparam int unsigned SUIT_W     = $clog2(STD_SUITS);
  localparam int unsigned CARD_W     = VAL_W + SUIT_W;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_POP_FRONT = 3'd1,
    REQ_POP_BACK  = 3'd2,
    REQ_SHUFFLE   = 3'd3,
    REQ_CLEAR     = 3'd4,
    REQ_LOAD      = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SH_RD,
    ST_SH_WR1,
    ST_SH_WR2,
    ST_LOAD,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic load_step;
    logic sh_read;
    logic sh_wr1;
    logic sh_wr2;
    logic emit;
  } cdss_cmd_t;

  typedef struct packed {
    logic load_busy;
    logic sh_swap;
    logic out_free;
  } cdss_sts_t;

endpackage

// ===== design/card_deck_store_with_shuffle.sv =====
// Top level of the card deck store with stepwise shuffle.
// Depends on cdss_pkg, cdss_ctrl and cdss_dpath.
//
// Usage:
//   Requests arrive on the input channel (in_valid_i / in_stall_o); each one
//   produces exactly one result transfer on the output channel (out_valid_o /
//   out_stall_i). A transfer happens at a rising edge with valid high and
//   stall low. One request is worked on at a time.
//   After the input transfer, append, pops, clear and unknown codes go
//   straight to the result state; a shuffle step reads both entries and,
//   if it swaps, then makes two writes through the single write port; the
//   standard load writes one card per cycle until the deck holds
//   min(capacity, MAX_CARDS, 52) cards. in_stall_o stays high until the
//   result is registered, so a new request is taken only once its
//   predecessor's result is in the output register. The capacity register
//   is written by cfg_we_i / cfg_wdata_i; the user must write it only while
//   idle, as the block itself does not enforce this.
// Reset:
//   The deck is empty, the cursor idle and the capacity 64. The card memory
//   is not cleared; only entries written since are ever read.
// Stall:
//   A finished result waits in the output register while out_stall_i is
//   high; the next request is still taken and worked on, and its result is
//   handed over once the register is free.
`timescale 1ns / 1ps

module card_deck_store_with_shuffle #(
  parameter int unsigned MAX_CARDS = cdss_pkg::MAX_CARDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: capacity limit
  input  logic                            cfg_we_i,
  input  logic [cdss_pkg::CNT_W-1:0]      cfg_wdata_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [cdss_pkg::REQ_W-1:0]      req_type_i,
  input  logic [cdss_pkg::VAL_W-1:0]      card_value_i,
  input  logic [cdss_pkg::SUIT_W-1:0]     card_suit_i,
  input  logic [cdss_pkg::FRAC_W-1:0]     rand_fraction_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            ok_o,
  output logic [cdss_pkg::VAL_W-1:0]      out_value_o,
  output logic [cdss_pkg::SUIT_W-1:0]     out_suit_o,
  output logic [cdss_pkg::CNT_W-1:0]      card_count_o,
  output logic                            shuffle_done_o
);
  import cdss_pkg::*;

  cdss_cmd_t cmd;
  cdss_sts_t sts;

  // Sequencer: accept in idle, walk the shuffle or load steps, then hand over
  cdss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Card memory, pointers, shuffle index and output register
  cdss_dpath #(
    .MAX_CARDS (MAX_CARDS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .card_value_i    (card_value_i),
    .card_suit_i     (card_suit_i),
    .rand_fraction_i (rand_fraction_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .ok_o            (ok_o),
    .out_value_o     (out_value_o),
    .out_suit_o      (out_suit_o),
    .card_count_o    (card_count_o),
    .shuffle_done_o  (shuffle_done_o)
  );

endmodule

// ===== design/cdss_ctrl.sv =====
// Controller of the card deck store: sequences one request through the
// datapath. Depends on cdss_pkg.
`timescale 1ns / 1ps

module cdss_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [cdss_pkg::REQ_W-1:0]      req_type_i,
  output logic                            in_stall_o,
  input  cdss_pkg::cdss_sts_t             sts_i,
  output cdss_pkg::cdss_cmd_t             cmd_o
);
  import cdss_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (req_type_i)
            REQ_SHUFFLE: state_d = ST_SH_RD;
            REQ_LOAD:    state_d = ST_LOAD;
            default:     state_d = ST_RESP;
          endcase
        end
      end
      ST_SH_RD:  state_d = sts_i.sh_swap ? ST_SH_WR1 : ST_RESP;
      ST_SH_WR1: state_d = ST_SH_WR2;
      ST_SH_WR2: state_d = ST_RESP;
      ST_LOAD:   state_d = sts_i.load_busy ? ST_LOAD : ST_RESP;
      ST_RESP:   state_d = sts_i.out_free ? ST_IDLE : ST_RESP;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_SH_RD:  cmd_o.sh_read   = 1'b1;
      ST_SH_WR1: cmd_o.sh_wr1    = 1'b1;
      ST_SH_WR2: cmd_o.sh_wr2    = 1'b1;
      ST_LOAD:   cmd_o.load_step = sts_i.load_busy;
      ST_RESP:   cmd_o.emit      = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/cdss_dpath.sv =====
// Datapath of the card deck store: circular card memory, count, head and
// shuffle cursor, index multiplier and output register. Depends on cdss_pkg.
`timescale 1ns / 1ps

module cdss_dpath #(
  parameter int unsigned MAX_CARDS = cdss_pkg::MAX_CARDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cdss_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic [cdss_pkg::REQ_W-1:0]      req_type_i,
  input  logic [cdss_pkg::VAL_W-1:0]      card_value_i,
  input  logic [cdss_pkg::SUIT_W-1:0]     card_suit_i,
  input  logic [cdss_pkg::FRAC_W-1:0]     rand_fraction_i,
  input  cdss_pkg::cdss_cmd_t             cmd_i,
  output cdss_pkg::cdss_sts_t             sts_o,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic                            ok_o,
  output logic [cdss_pkg::VAL_W-1:0]      out_value_o,
  output logic [cdss_pkg::SUIT_W-1:0]     out_suit_o,
  output logic [cdss_pkg::CNT_W-1:0]      card_count_o,
  output logic                            shuffle_done_o
);
  import cdss_pkg::*;

  localparam int unsigned PW   = $clog2(MAX_CARDS);
  localparam int unsigned SW   = PW + 1;
  localparam int unsigned PR_W = FRAC_W + CNT_W;

  // Logical position k maps to (head + k) wrapped at the memory depth
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                         input logic [CNT_W-1:0] k);
    logic [SW-1:0] s;
    s = {1'b0, base} + SW'(k);
    if (s >= SW'(MAX_CARDS)) s = s - SW'(MAX_CARDS);
    return s[PW-1:0];
  endfunction

  logic [CARD_W-1:0] mem [MAX_CARDS];

  logic [CNT_W-1:0]  cap_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PW-1:0]     head_q, head_d;
  logic [CNT_W-1:0]  cursor_q, cursor_d;
  logic              out_valid_q;

  logic              ok_q, ok_d;
  logic              pop_q, pop_d;
  logic              swap_q, swap_d;
  logic [CNT_W-1:0]  load_n_q, load_n_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [CARD_W-1:0] rd_a_q, rd_b_q;
  logic              out_ok_q;
  logic [CARD_W-1:0] out_card_q;
  logic [CNT_W-1:0]  out_count_q;
  logic              out_done_q;

  logic [CNT_W-1:0]  cap_now, load_n;
  logic              cur_idle, sh_swap;
  logic [CNT_W-1:0]  sh_i, sh_i1, sh_j;
  logic [PR_W-1:0]   prod;
  logic [PW-1:0]     head_inc;
  logic              out_free;

  logic              we, re_a, re_b;
  logic [PW-1:0]     wa, ra_a, ra_b;
  logic [CARD_W-1:0] wd;

  assign cap_now  = (32'(cap_q) > 32'(MAX_CARDS)) ? CNT_W'(MAX_CARDS) : cap_q;
  assign load_n   = (cap_now > CNT_W'(STD_DECK)) ? CNT_W'(STD_DECK) : cap_now;
  assign head_inc = (head_q == PW'(MAX_CARDS - 1)) ? '0 : head_q + 1'b1;

  // Stale or zero cursor starts a new pass from the last card
  assign cur_idle = (cursor_q == '0) || (cursor_q >= count_q);
  assign sh_swap  = !(cur_idle && (count_q < CNT_W'(2)));
  assign sh_i     = cur_idle ? count_q - 1'b1 : cursor_q;
  assign sh_i1    = sh_i + 1'b1;
  assign prod     = PR_W'(rand_fraction_i) * PR_W'(sh_i1);
  assign sh_j     = prod[FRAC_W +: CNT_W];

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    count_d  = count_q;
    head_d   = head_q;
    cursor_d = cursor_q;
    ok_d     = ok_q;
    pop_d    = pop_q;
    swap_d   = swap_q;
    load_n_d = load_n_q;
    i_d      = i_q;
    j_d      = j_q;
    we       = 1'b0;
    wa       = phys(head_q, count_q);
    wd       = {card_suit_i, card_value_i};
    re_a     = 1'b0;
    ra_a     = phys(head_q, i_q);
    re_b     = 1'b0;
    ra_b     = phys(head_q, j_q);

    if (cmd_i.accept) begin
      ok_d  = 1'b0;
      pop_d = 1'b0;
      unique case (req_type_i)
        REQ_APPEND: begin
          cursor_d = '0;
          if (count_q < cap_now) begin
            we      = 1'b1;
            count_d = count_q + 1'b1;
            ok_d    = 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          cursor_d = '0;
          if (count_q != '0) begin
            re_a    = 1'b1;
            ra_a    = head_q;
            head_d  = head_inc;
            count_d = count_q - 1'b1;
            ok_d    = 1'b1;
            pop_d   = 1'b1;
          end
        end
        REQ_POP_BACK: begin
          cursor_d = '0;
          if (count_q != '0) begin
            re_a    = 1'b1;
            ra_a    = phys(head_q, count_q - 1'b1);
            count_d = count_q - 1'b1;
            ok_d    = 1'b1;
            pop_d   = 1'b1;
          end
        end
        REQ_SHUFFLE: begin
          ok_d     = (count_q != '0);
          swap_d   = sh_swap;
          i_d      = sh_i;
          j_d      = sh_j;
          cursor_d = sh_swap ? sh_i - 1'b1 : '0;
        end
        REQ_CLEAR: begin
          cursor_d = '0;
          count_d  = '0;
          ok_d     = 1'b1;
        end
        REQ_LOAD: begin
          cursor_d = '0;
          count_d  = '0;
          ok_d     = 1'b1;
          load_n_d = load_n;
        end
        default: ;
      endcase
    end

    // Standard order: position k holds value k / suits, suit k % suits
    if (cmd_i.load_step && (count_q < load_n_q)) begin
      we      = 1'b1;
      wd      = {count_q[SUIT_W-1:0], VAL_W'(count_q >> SUIT_W)};
      count_d = count_q + 1'b1;
    end

    if (cmd_i.sh_read) begin
      re_a = 1'b1;
      re_b = 1'b1;
    end

    if (cmd_i.sh_wr1) begin
      we = 1'b1;
      wa = phys(head_q, i_q);
      wd = rd_b_q;
    end

    if (cmd_i.sh_wr2) begin
      we = 1'b1;
      wa = phys(head_q, j_q);
      wd = rd_a_q;
    end
  end

  // Card memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re_a) rd_a_q <= mem[ra_a];
    if (re_b) rd_b_q <= mem[ra_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      head_q      <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      count_q  <= count_d;
      head_q   <= head_d;
      cursor_q <= cursor_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q     <= ok_d;
    pop_q    <= pop_d;
    swap_q   <= swap_d;
    load_n_q <= load_n_d;
    i_q      <= i_d;
    j_q      <= j_d;
    if (cmd_i.emit) begin
      out_ok_q    <= ok_q;
      out_card_q  <= pop_q ? rd_a_q : '0;
      out_count_q <= count_q;
      out_done_q  <= (cursor_q == '0);
    end
  end

  assign sts_o.load_busy = (count_q < load_n_q);
  assign sts_o.sh_swap   = swap_q;
  assign sts_o.out_free  = out_free;

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_ok_q;
  assign out_value_o    = out_card_q[VAL_W-1:0];
  assign out_suit_o     = out_card_q[CARD_W-1:VAL_W];
  assign card_count_o   = out_count_q;
  assign shuffle_done_o = out_done_q;

endmodule

// ===== dv/tb_card_deck_store_with_shuffle.sv =====
// Self-checking testbench for card_deck_store_with_shuffle: a directed table,
// then random phases across capacities and idling modes, checked by a predictor.
// Depends on cdss_pkg and the card_deck_store_with_shuffle RTL.
`timescale 1ns / 1ps

module tb_card_deck_store_with_shuffle;
  import cdss_pkg::*;

  // Request codes the block does not define; they must leave the deck alone.
  localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  // Longest request is a full standard load.
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS  = 95;
  localparam int unsigned N_PHASES     = 8;
  localparam int unsigned N_DIR        = 29;

  typedef struct packed {
    logic              ok;
    logic [VAL_W-1:0]  value;
    logic [SUIT_W-1:0] suit;
    logic [CNT_W-1:0]  count;
    logic              done;
  } deck_result_t;

  // One row of the directed table: either a capacity write or a request,
  // with the result typed in where it is obvious.
  typedef struct packed {
    logic              is_cfg;
    logic [CNT_W-1:0]  cap;
    logic [REQ_W-1:0]  req;
    logic [VAL_W-1:0]  val;
    logic [SUIT_W-1:0] suit;
    logic [FRAC_W-1:0] frac;
    logic              typed;
    deck_result_t      want;
  } deck_row_t;

  localparam deck_result_t NO_CHECK = '0;

  localparam deck_row_t DIR_ROWS [N_DIR] = '{
    // empty deck: pops, shuffle and an unknown code all fail
    '{1'b0, 7'd0, REQ_POP_FRONT, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b0, 4'd0, 2'd0, 7'd0, 1'b1}},
    '{1'b0, 7'd0, REQ_POP_BACK, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b0, 4'd0, 2'd0, 7'd0, 1'b1}},
    '{1'b0, 7'd0, REQ_SHUFFLE, 4'd0, 2'd0, 16'hFFFF, 1'b1,
      '{1'b0, 4'd0, 2'd0, 7'd0, 1'b1}},
    '{1'b0, 7'd0, REQ_RSVD_A, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b0, 4'd0, 2'd0, 7'd0, 1'b1}},
    // single card: shuffle swaps nothing, pop back returns it
    '{1'b0, 7'd0, REQ_APPEND, 4'd15, 2'd3, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd1, 1'b1}},
    '{1'b0, 7'd0, REQ_SHUFFLE, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd1, 1'b1}},
    '{1'b0, 7'd0, REQ_POP_BACK, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b1, 4'd15, 2'd3, 7'd0, 1'b1}},
    '{1'b0, 7'd0, REQ_APPEND, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd1, 1'b1}},
    '{1'b0, 7'd0, REQ_APPEND, 4'd12, 2'd2, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd2, 1'b1}},
    '{1'b0, 7'd0, REQ_CLEAR, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd0, 1'b1}},
    // standard order: ace of suit 0 at the front, king of suit 3 at the back
    '{1'b0, 7'd0, REQ_LOAD, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd52, 1'b1}},
    '{1'b0, 7'd0, REQ_POP_FRONT, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd51, 1'b1}},
    '{1'b0, 7'd0, REQ_POP_BACK, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b1, 4'd12, 2'd3, 7'd50, 1'b1}},
    // shuffle in progress, unknown code keeps it, append cancels it
    '{1'b0, 7'd0, REQ_SHUFFLE, 4'd0, 2'd0, 16'h0000, 1'b0, NO_CHECK},
    '{1'b0, 7'd0, REQ_SHUFFLE, 4'd0, 2'd0, 16'hFFFF, 1'b0, NO_CHECK},
    '{1'b0, 7'd0, REQ_RSVD_B, 4'd0, 2'd0, 16'h0000, 1'b0, NO_CHECK},
    '{1'b0, 7'd0, REQ_SHUFFLE, 4'd0, 2'd0, 16'h8000, 1'b0, NO_CHECK},
    '{1'b0, 7'd0, REQ_APPEND, 4'd5, 2'd1, 16'h0000, 1'b0, NO_CHECK},
    // capacity lowered below the held count: deck counts as full
    '{1'b1, 7'd2, REQ_APPEND, 4'd0, 2'd0, 16'h0000, 1'b0, NO_CHECK},
    '{1'b0, 7'd0, REQ_APPEND, 4'd7, 2'd2, 16'h0000, 1'b1,
      '{1'b0, 4'd0, 2'd0, 7'd51, 1'b1}},
    '{1'b0, 7'd0, REQ_LOAD, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd2, 1'b1}},
    // two cards: the shuffle ends after one step, then starts afresh
    '{1'b0, 7'd0, REQ_SHUFFLE, 4'd0, 2'd0, 16'hFFFF, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd2, 1'b1}},
    '{1'b0, 7'd0, REQ_SHUFFLE, 4'd0, 2'd0, 16'h0000, 1'b0, NO_CHECK},
    // zero capacity: load holds nothing, append fails
    '{1'b1, 7'd0, REQ_APPEND, 4'd0, 2'd0, 16'h0000, 1'b0, NO_CHECK},
    '{1'b0, 7'd0, REQ_LOAD, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd0, 1'b1}},
    '{1'b0, 7'd0, REQ_APPEND, 4'd1, 2'd1, 16'h0000, 1'b1,
      '{1'b0, 4'd0, 2'd0, 7'd0, 1'b1}},
    // capacity above the store size acts as the store size
    '{1'b1, 7'd127, REQ_APPEND, 4'd0, 2'd0, 16'h0000, 1'b0, NO_CHECK},
    '{1'b0, 7'd0, REQ_LOAD, 4'd0, 2'd0, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd52, 1'b1}},
    '{1'b0, 7'd0, REQ_APPEND, 4'd15, 2'd3, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 2'd0, 7'd53, 1'b1}}
  };

  // Capacities swept by the random phases, extremes included.
  localparam logic [CNT_W-1:0] PHASE_CAPS [N_PHASES] = '{
    7'd64, 7'd1, 7'd127, 7'd0, 7'd3, 7'd52, 7'd53, 7'd20
  };

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i     = '0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [REQ_W-1:0]  req_type_i      = '0;
  logic [VAL_W-1:0]  card_value_i    = '0;
  logic [SUIT_W-1:0] card_suit_i     = '0;
  logic [FRAC_W-1:0] rand_fraction_i = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic              ok_o;
  logic [VAL_W-1:0]  out_value_o;
  logic [SUIT_W-1:0] out_suit_o;
  logic [CNT_W-1:0]  card_count_o;
  logic              shuffle_done_o;

  // Predicted deck contents and control state.
  logic [CARD_W-1:0] deck_cards [MAX_CARDS_DEF];
  int unsigned       deck_count  = 0;
  int unsigned       shuffle_pos = 0;
  logic [CNT_W-1:0]  deck_cap    = CAP_RESET;

  deck_result_t      pending_results [$];
  int unsigned       error_count     = 0;
  int unsigned       results_seen    = 0;
  int unsigned       cycle_count     = 0;
  int unsigned       send_idle_pct   = 0;
  int unsigned       recv_stall_pct  = 0;

  always #2 clk_i = ~clk_i;

  card_deck_store_with_shuffle u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .card_value_i   (card_value_i),
    .card_suit_i    (card_suit_i),
    .rand_fraction_i(rand_fraction_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .out_value_o    (out_value_o),
    .out_suit_o     (out_suit_o),
    .card_count_o   (card_count_o),
    .shuffle_done_o (shuffle_done_o)
  );

  // Advance the predicted deck by one request and return its result.
  function automatic deck_result_t apply_request(input logic [REQ_W-1:0]  req,
                                                 input logic [VAL_W-1:0]  val,
                                                 input logic [SUIT_W-1:0] suit,
                                                 input logic [FRAC_W-1:0] frac);
    deck_result_t      res;
    logic [CARD_W-1:0] got;
    logic [CARD_W-1:0] tmp;
    int unsigned       cap;
    int unsigned       i;
    int unsigned       j;
    res = '0;
    got = '0;
    cap = (deck_cap > MAX_CARDS_DEF) ? MAX_CARDS_DEF : deck_cap;
    // Every defined request apart from a shuffle step cancels the shuffle.
    if (req inside {REQ_APPEND, REQ_POP_FRONT, REQ_POP_BACK, REQ_CLEAR, REQ_LOAD}) begin
      shuffle_pos = 0;
    end
    case (req)
      REQ_APPEND: begin
        if (deck_count < cap) begin
          deck_cards[deck_count] = {suit, val};
          deck_count++;
          res.ok = 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (deck_count > 0) begin
          got = deck_cards[0];
          for (int k = 0; k + 1 < deck_count; k++) deck_cards[k] = deck_cards[k + 1];
          deck_count--;
          res.ok = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (deck_count > 0) begin
          deck_count--;
          got = deck_cards[deck_count];
          res.ok = 1'b1;
        end
      end
      REQ_SHUFFLE: begin
        res.ok = (deck_count != 0);
        // An idle or stale cursor restarts the walk from the back.
        if (shuffle_pos == 0 || shuffle_pos >= deck_count) begin
          i = (deck_count < 2) ? 0 : deck_count - 1;
        end else begin
          i = shuffle_pos;
        end
        if (i == 0) begin
          shuffle_pos = 0;
        end else begin
          j = (int'(frac) * (i + 1)) >> FRAC_W;
          if (j > i) j = i;
          tmp           = deck_cards[i];
          deck_cards[i] = deck_cards[j];
          deck_cards[j] = tmp;
          shuffle_pos   = i - 1;
        end
      end
      REQ_CLEAR: begin
        deck_count = 0;
        res.ok     = 1'b1;
      end
      REQ_LOAD: begin
        deck_count = 0;
        for (int v = 0; v < STD_VALUES; v++) begin
          for (int s = 0; s < STD_SUITS; s++) begin
            if (deck_count < cap && deck_count < STD_DECK) begin
              deck_cards[deck_count] = {s[SUIT_W-1:0], v[VAL_W-1:0]};
              deck_count++;
            end
          end
        end
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.value = got[VAL_W-1:0];
    res.suit  = got[CARD_W-1:VAL_W];
    res.count = deck_count[CNT_W-1:0];
    res.done  = (shuffle_pos == 0);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    $display("mismatch at result %0d: %s expected %0d, got %0d",
             results_seen, what, want_v, got_v);
    error_count++;
  endtask

  task automatic check_field(input string what, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) report_mismatch(what, want_v, got_v);
  endtask

  // Drive one request, hold it until transferred, then record its result.
  task automatic send_req(input logic [REQ_W-1:0]  req,
                          input logic [VAL_W-1:0]  val,
                          input logic [SUIT_W-1:0] suit,
                          input logic [FRAC_W-1:0] frac,
                          input logic              typed,
                          input deck_result_t      want);
    deck_result_t pred;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    card_value_i    <= val;
    card_suit_i     <= suit;
    rand_fraction_i <= frac;
    do @(posedge clk_i); while (in_stall_o);
    pred = apply_request(req, val, suit, frac);
    pending_results.push_back(typed ? want : pred);
  endtask

  // Write the capacity only once every pending result has been transferred.
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    deck_cap = cap;
  endtask

  // Mostly random, with both fraction extremes turning up often.
  function automatic logic [FRAC_W-1:0] pick_fraction();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned run;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // Walk a shuffle through to its end and into a fresh start, mostly.
        run = deck_count + 1;
        if ($urandom_range(3) == 0) run = $urandom_range(1, deck_count + 1);
        if (run > n_items - sent) run = n_items - sent;
        for (int k = 0; k < run; k++) begin
          send_req(REQ_SHUFFLE, VAL_W'($urandom), SUIT_W'($urandom),
                   pick_fraction(), 1'b0, NO_CHECK);
        end
        sent += run;
      end else if (pick < 47) begin
        send_req(REQ_LOAD, VAL_W'($urandom), SUIT_W'($urandom), pick_fraction(),
                 1'b0, NO_CHECK);
        sent++;
      end else if (pick < 67) begin
        run = $urandom_range(1, 8);
        if (run > n_items - sent) run = n_items - sent;
        for (int k = 0; k < run; k++) begin
          send_req(REQ_APPEND, VAL_W'($urandom_range(15)), SUIT_W'($urandom_range(3)),
                   pick_fraction(), 1'b0, NO_CHECK);
        end
        sent += run;
      end else if (pick < 92) begin
        send_req((pick < 77) ? REQ_POP_FRONT : (pick < 87) ? REQ_POP_BACK : REQ_CLEAR,
                 VAL_W'($urandom), SUIT_W'($urandom), pick_fraction(), 1'b0, NO_CHECK);
        sent++;
      end else begin
        // Unknown codes must leave the deck and the cursor alone.
        send_req($urandom_range(1) ? REQ_RSVD_A : REQ_RSVD_B, VAL_W'($urandom),
                 SUIT_W'($urandom), pick_fraction(), 1'b0, NO_CHECK);
        sent++;
      end
    end
  endtask

  // Result side: check each transfer against the oldest expectation, then
  // pick the stall for the next cycle.
  always @(posedge clk_i) begin : result_check
    deck_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, card_count", 0, card_count_o);
      end else begin
        want = pending_results.pop_front();
        check_field("ok", want.ok, ok_o);
        check_field("out_value", want.value, out_value_o);
        check_field("out_suit", want.suit, out_suit_o);
        check_field("card_count", want.count, card_count_o);
        check_field("shuffle_done", want.done, shuffle_done_o);
      end
    end
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, with light idling on both sides.
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].is_cfg) begin
        write_capacity(DIR_ROWS[r].cap);
      end else begin
        send_req(DIR_ROWS[r].req, DIR_ROWS[r].val, DIR_ROWS[r].suit, DIR_ROWS[r].frac,
                 DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end
    end

    // Random phases: each with its own capacity and idling mode.
    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(PHASE_CAPS[p]);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      run_random(PHASE_ITEMS);
    end

    // Drain, then give any stray result time to show up.
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/cdss_pkg.sv
design/cdss_ctrl.sv
design/cdss_dpath.sv
design/card_deck_store_with_shuffle.sv
dv/tb_card_deck_store_with_shuffle.sv
